// File: hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex ALU package
// Shared types, constants and arithmetic helpers for the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;

   localparam int SUMD_W = DATA_WIDTH + 1;          // add/sub/negate result
   localparam int PROD_W = 2 * DATA_WIDTH;          // one 16x16 product
   localparam int MAG_W  = PROD_W + 1;              // magnitude of a sum of products
   localparam int NUM_W  = MAG_W + FRAC_BITS + 1;   // scaled divide numerator
   localparam int QUO_W  = DATA_WIDTH + 1;          // divide quotient bits
   localparam int CMP_W  = MAG_W + QUO_W;           // shifted divisor
   localparam int DIV_STEPS = QUO_W + 1;            // overflow check + quotient bits
   localparam int SQ_W      = PROD_W + 1;           // square root working width
   localparam int SQ_STEPS  = DATA_WIDTH;

   localparam int ANG_FRAC     = 24;
   localparam int CORDIC_STEPS = 25;
   localparam int XY_W         = DATA_WIDTH + 4;
   localparam int Z_W          = 28;
   localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
   localparam logic signed [Z_W-1:0] PI_ANG = 28'sd52707178;
   localparam logic [DATA_WIDTH-1:0] PI_Q =
      DATA_WIDTH'((52707178 + (1 << (ANG_SH - 1))) >> ANG_SH);

   localparam logic signed [Z_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117,   28'sd262123,  28'sd131069,  28'sd65536,   28'sd32768,
      28'sd16384,    28'sd8192,    28'sd4096,    28'sd2048,    28'sd1024,
      28'sd512,      28'sd256,     28'sd128,     28'sd64,      28'sd32,
      28'sd16,       28'sd8,       28'sd4,       28'sd2,       28'sd1
   };

   localparam int REQ_DEPTH = 4;
   localparam int REQ_AW    = $clog2(REQ_DEPTH);
   localparam int REQ_CW    = $clog2(REQ_DEPTH + 1);
   localparam int RSP_DEPTH = 32;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIV   = 3'd3,
      OP_MOD   = 3'd4,
      OP_ARG   = 3'd5,
      OP_CONJ  = 3'd6,
      OP_EQUAL = 3'd7
   } op_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [DATA_WIDTH-1:0] a_re;
      logic [DATA_WIDTH-1:0] a_im;
      logic [DATA_WIDTH-1:0] b_re;
      logic [DATA_WIDTH-1:0] b_im;
   } req_item_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] res_re;
      logic [DATA_WIDTH-1:0] res_im;
      logic                  is_equal;
      logic [1:0]            status;
   } rsp_item_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type                op;
      logic                  div_zero;
      logic                  y_zero;
      logic                  x_neg;
      logic [DATA_WIDTH-1:0] a_re;
      logic [DATA_WIDTH-1:0] a_im;
      logic [DATA_WIDTH-1:0] b_re;
      logic [DATA_WIDTH-1:0] b_im;
   } cmd_type;

   // record carried down the iteration chain
   typedef struct packed {
      op_type                  op;
      logic [DATA_WIDTH-1:0]   pre_re;
      logic [DATA_WIDTH-1:0]   pre_im;
      logic                    pre_sat;
      logic                    pre_eq;
      logic                    div_zero;
      logic                    y_zero;
      logic                    x_neg;
      logic [MAG_W-1:0]        den;
      logic [1:0][NUM_W-1:0]   drem;
      logic [1:0][QUO_W-1:0]   dquo;
      logic [1:0]              dovf;
      logic [1:0]              dneg;
      logic [SQ_W-1:0]         srem;
      logic [SQ_W-1:0]         sres;
      logic signed [XY_W-1:0]  cx;
      logic signed [XY_W-1:0]  cy;
      logic signed [Z_W-1:0]   cz;
   } work_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] val;
      logic                  ovf;
   } sat_type;

   // clamp a sign/magnitude value to the signed data range
   function automatic sat_type sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
      sat_type          r;
      logic [MAG_W-1:0] lim;
      lim = MAG_W'(1) << (DATA_WIDTH - 1);
      if (!neg) begin
         if (mag >= lim) begin
            r.val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            r.ovf = 1'b1;
         end else begin
            r.val = mag[DATA_WIDTH-1:0];
            r.ovf = 1'b0;
         end
      end else if (mag > lim) begin
         r.val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         r.ovf = 1'b1;
      end else begin
         r.val = DATA_WIDTH'(0) - mag[DATA_WIDTH-1:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   function automatic sat_type sat_int(input logic signed [SUMD_W-1:0] v);
      logic [SUMD_W-1:0] m;
      m = v[SUMD_W-1] ? (~v + 1'b1) : v;
      return sat_mag(v[SUMD_W-1], MAG_W'(m));
   endfunction

   // one chain stage: CORDIC rotation, divide bit and square root bit
   function automatic work_type cau_step(input work_type w, input int k);
      work_type               r;
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic [CMP_W-1:0]       dsh;
      logic [CMP_W-1:0]       remx;
      logic [SQ_W-1:0]        bitv;
      logic [SQ_W-1:0]        trial;
      r  = w;
      xs = w.cx >>> k;
      ys = w.cy >>> k;
      if (!w.cy[XY_W-1]) begin
         r.cx = w.cx + ys;
         r.cy = w.cy - xs;
         r.cz = w.cz + ATAN_TAB[k];
      end else begin
         r.cx = w.cx - ys;
         r.cy = w.cy + xs;
         r.cz = w.cz - ATAN_TAB[k];
      end
      if (k < DIV_STEPS) begin
         dsh = CMP_W'(w.den) << (QUO_W - k);
         for (int p = 0; p < 2; p++) begin
            remx = CMP_W'(w.drem[p]);
            if (k == 0) begin
               r.dovf[p] = (remx >= dsh);
            end else if (remx >= dsh) begin
               r.drem[p] = NUM_W'(remx - dsh);
               r.dquo[p][QUO_W-k] = 1'b1;
            end
         end
      end
      if (k < SQ_STEPS) begin
         bitv  = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
         trial = w.sres + bitv;
         if (w.srem >= trial) begin
            r.srem = w.srem - trial;
            r.sres = (w.sres >> 1) + bitv;
         end else begin
            r.sres = w.sres >> 1;
         end
      end
      return r;
   endfunction

endpackage

// File: hdl/cau_front.sv
// ----------------------------------------------------------------------------
// Complex ALU front end
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_item_type req_data,
   input  logic         cmd_pop,
   output logic         cmd_empty,
   output cmd_type      cmd_data
);

   cmd_type           mem_ff [REQ_DEPTH];
   logic [REQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [REQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [REQ_CW-1:0] count_ff, count_in;
   cmd_type           cls;
   logic              do_push, do_pop;

   always_comb begin
      cls.op       = op_type'(req_data.req_type);
      cls.div_zero = (req_data.b_re == '0) && (req_data.b_im == '0);
      cls.y_zero   = (req_data.a_im == '0);
      cls.x_neg    = req_data.a_re[DATA_WIDTH-1];
      cls.a_re     = req_data.a_re;
      cls.a_im     = req_data.a_im;
      cls.b_re     = req_data.b_re;
      cls.b_im     = req_data.b_im;
   end

   assign req_full  = (count_ff == REQ_CW'(REQ_DEPTH));
   assign cmd_empty = (count_ff == '0);
   assign cmd_data  = mem_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && !cmd_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + REQ_CW'(do_push) - REQ_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// File: hdl/cau_back.sv
// ----------------------------------------------------------------------------
// Complex ALU back end
// Products, operand prep, a 25-stage iteration chain and result assembly.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  cmd_type      in_cmd,
   output logic         out_valid,
   output rsp_item_type out_rsp
);

   // product stage
   logic                     vld_p_ff;
   cmd_type                  cmd_p_ff;
   logic signed [PROD_W-1:0] m_rr_ff, m_ii_ff, m_ri_ff, m_ir_ff, sq0_ff, sq1_ff;
   logic signed [DATA_WIDTH-1:0] u_sel, v_sel;

   // chain
   logic     cvld_ff [0:CORDIC_STEPS];
   work_type chain_ff [0:CORDIC_STEPS];
   work_type prep_in;

   // output
   logic         out_vld_ff;
   rsp_item_type out_ff, out_in;

   assign u_sel = (in_cmd.op == OP_MOD) ? $signed(in_cmd.a_re) : $signed(in_cmd.b_re);
   assign v_sel = (in_cmd.op == OP_MOD) ? $signed(in_cmd.a_im) : $signed(in_cmd.b_im);

   always_ff @(posedge clock) begin
      cmd_p_ff <= in_cmd;
      m_rr_ff  <= $signed(in_cmd.a_re) * $signed(in_cmd.b_re);
      m_ii_ff  <= $signed(in_cmd.a_im) * $signed(in_cmd.b_im);
      m_ri_ff  <= $signed(in_cmd.a_re) * $signed(in_cmd.b_im);
      m_ir_ff  <= $signed(in_cmd.a_im) * $signed(in_cmd.b_re);
      sq0_ff   <= u_sel * u_sel;
      sq1_ff   <= v_sel * v_sel;
   end

   // operand prep: short ops finish here, long ops get their start values
   always_comb begin
      logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;
      logic signed [SUMD_W-1:0]     s_re, s_im;
      logic signed [MAG_W-1:0]      p_m, q_m, p_d, q_d;
      logic [MAG_W-1:0]             pm, qm, pdm, qdm;
      sat_type                      r_re, r_im;
      ar = $signed(cmd_p_ff.a_re);
      ai = $signed(cmd_p_ff.a_im);
      br = $signed(cmd_p_ff.b_re);
      bi = $signed(cmd_p_ff.b_im);
      s_re = '0;
      s_im = '0;
      case (cmd_p_ff.op)
         OP_ADD: begin
            s_re = ar + br;
            s_im = ai + bi;
         end
         OP_SUB: begin
            s_re = ar - br;
            s_im = ai - bi;
         end
         OP_CONJ: begin
            s_re = ar;
            s_im = -ai;
         end
         default: ;
      endcase
      // multiply, rounded half away from zero
      p_m = MAG_W'(m_rr_ff) - MAG_W'(m_ii_ff);
      q_m = MAG_W'(m_ri_ff) + MAG_W'(m_ir_ff);
      pm  = p_m[MAG_W-1] ? (~p_m + 1'b1) : p_m;
      qm  = q_m[MAG_W-1] ? (~q_m + 1'b1) : q_m;
      pm  = (pm + (MAG_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      qm  = (qm + (MAG_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (cmd_p_ff.op == OP_MUL) begin
         r_re = sat_mag(p_m[MAG_W-1], pm);
         r_im = sat_mag(q_m[MAG_W-1], qm);
      end else begin
         r_re = sat_int(s_re);
         r_im = sat_int(s_im);
      end
      // divide numerators a * conj(b)
      p_d = MAG_W'(m_rr_ff) + MAG_W'(m_ii_ff);
      q_d = MAG_W'(m_ir_ff) - MAG_W'(m_ri_ff);
      pdm = p_d[MAG_W-1] ? (~p_d + 1'b1) : p_d;
      qdm = q_d[MAG_W-1] ? (~q_d + 1'b1) : q_d;

      prep_in.op       = cmd_p_ff.op;
      prep_in.pre_re   = r_re.val;
      prep_in.pre_im   = r_im.val;
      prep_in.pre_sat  = r_re.ovf || r_im.ovf;
      prep_in.pre_eq   = (cmd_p_ff.a_re == cmd_p_ff.b_re) && (cmd_p_ff.a_im == cmd_p_ff.b_im);
      prep_in.div_zero = cmd_p_ff.div_zero;
      prep_in.y_zero   = cmd_p_ff.y_zero;
      prep_in.x_neg    = cmd_p_ff.x_neg;
      prep_in.den      = MAG_W'($unsigned(sq0_ff)) + MAG_W'($unsigned(sq1_ff));
      prep_in.drem[0]  = NUM_W'(pdm) << (FRAC_BITS + 1);
      prep_in.drem[1]  = NUM_W'(qdm) << (FRAC_BITS + 1);
      prep_in.dquo     = '0;
      prep_in.dovf     = '0;
      prep_in.dneg     = {q_d[MAG_W-1], p_d[MAG_W-1]};
      prep_in.srem     = SQ_W'(prep_in.den);
      prep_in.sres     = '0;
      // half-turn pre-rotation for the left half plane
      if (cmd_p_ff.x_neg) begin
         prep_in.cx = -XY_W'(ar);
         prep_in.cy = -XY_W'(ai);
         prep_in.cz = ai[DATA_WIDTH-1] ? -PI_ANG : PI_ANG;
      end else begin
         prep_in.cx = XY_W'(ar);
         prep_in.cy = XY_W'(ai);
         prep_in.cz = '0;
      end
   end

   always_ff @(posedge clock) begin
      chain_ff[0] <= prep_in;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         chain_ff[k+1] <= cau_step(chain_ff[k], k);
      end
   end

   // result assembly
   always_comb begin
      work_type             w;
      sat_type              d_re, d_im, s_md, s_ag;
      logic [QUO_W:0]       t0, t1;
      logic [SQ_W-1:0]      s;
      logic [Z_W-1:0]       zm;
      logic                 sat;
      w  = chain_ff[CORDIC_STEPS];
      t0 = ({1'b0, w.dquo[0]} + 1'b1) >> 1;
      t1 = ({1'b0, w.dquo[1]} + 1'b1) >> 1;
      d_re = sat_mag(w.dneg[0], w.dovf[0] ? (MAG_W'(1) << DATA_WIDTH) : MAG_W'(t0));
      d_im = sat_mag(w.dneg[1], w.dovf[1] ? (MAG_W'(1) << DATA_WIDTH) : MAG_W'(t1));
      s    = (w.srem > w.sres) ? w.sres + 1'b1 : w.sres;
      s_md = sat_mag(1'b0, MAG_W'(s));
      zm   = w.cz[Z_W-1] ? (~w.cz + 1'b1) : w.cz;
      zm   = (zm + (Z_W'(1) << (ANG_SH - 1))) >> ANG_SH;
      s_ag = sat_mag(w.cz[Z_W-1], MAG_W'(zm));
      if (w.y_zero) begin
         s_ag.val = w.x_neg ? PI_Q : '0;
         s_ag.ovf = 1'b0;
      end
      out_in.is_equal = 1'b0;
      out_in.status   = ST_OK;
      sat             = 1'b0;
      case (w.op)
         OP_DIV: begin
            if (w.div_zero) begin
               out_in.res_re = '0;
               out_in.res_im = '0;
               out_in.status = ST_DIV0;
            end else begin
               out_in.res_re = d_re.val;
               out_in.res_im = d_im.val;
               sat           = d_re.ovf || d_im.ovf;
            end
         end
         OP_MOD: begin
            out_in.res_re = s_md.val;
            out_in.res_im = '0;
            sat           = s_md.ovf;
         end
         OP_ARG: begin
            out_in.res_re = s_ag.val;
            out_in.res_im = '0;
            sat           = s_ag.ovf;
         end
         OP_EQUAL: begin
            out_in.res_re   = '0;
            out_in.res_im   = '0;
            out_in.is_equal = w.pre_eq;
         end
         default: begin
            out_in.res_re = w.pre_re;
            out_in.res_im = w.pre_im;
            sat           = w.pre_sat;
         end
      endcase
      if (sat) begin
         out_in.status = ST_SAT;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            cvld_ff[k] <= 1'b0;
         end
      end else begin
         vld_p_ff   <= in_valid;
         cvld_ff[0] <= vld_p_ff;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            cvld_ff[k+1] <= cvld_ff[k];
         end
         out_vld_ff <= cvld_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_rsp   = out_ff;

endmodule

// File: hdl/cau_rsp_fifo.sv
// ----------------------------------------------------------------------------
// Complex ALU result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module cau_rsp_fifo import cau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_data,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type head
);

   rsp_item_type      mem_ff [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CW-1:0] count_ff, count_in;
   logic              do_pop;

   assign empty    = (count_ff == '0);
   assign head     = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;
   assign count_in = count_ff + RSP_CW'(push) - RSP_CW'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != RSP_CW'(RSP_DEPTH)) || do_pop)
      else $error("result queue overrun");

endmodule

// File: hdl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Complex ALU top level
// Queue-style request/result ports around a pipelined complex-number ALU.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while req_full is low and returns
// one result per request, in request order. A request is a 3-bit opcode
// (add, sub, mul, div, mod, arg, conj, equal) and two Q8.8 complex
// operands; the result is a Q8.8 complex value (or a scalar in res_re
// for mod and arg), an equal flag and a status (ok, divide by zero,
// saturated). Every request, whatever its opcode, runs down the same
// pipeline, whose depth comes from the 25-stage CORDIC chain used for
// arg; the divider (one quotient bit per stage) and the square root (one
// root bit per stage) share the same chain stages. Sustained throughput
// is one transfer per cycle on each side while neither side stalls. A
// 4-entry request queue and a 32-entry result queue decouple the two
// sides; requests are issued into the pipeline only while a result slot
// is reserved for them, so stalling the result side simply backs the
// request side up to full.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_item_type req_data,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output rsp_item_type rsp_data
);

   logic              cmd_empty;
   cmd_type           cmd_data;
   logic              issue;
   logic              rsp_take;
   logic              back_valid;
   rsp_item_type      back_rsp;
   // requests issued and not yet popped: in flight plus queued results
   logic [RSP_CW-1:0] pending_ff, pending_in;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_pop   (issue),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data)
   );

   // issue only while a result slot can be reserved
   assign issue    = !cmd_empty && (pending_ff != RSP_CW'(RSP_DEPTH));
   assign rsp_take = rsp_pop && !rsp_empty;

   always_comb begin
      pending_in = pending_ff + RSP_CW'(issue) - RSP_CW'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_cmd    (cmd_data),
      .out_valid (back_valid),
      .out_rsp   (back_rsp)
   );

   cau_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_rsp),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= RSP_CW'(RSP_DEPTH))
      else $error("reserved result slots exceed queue depth");

   assert property (@(posedge clock) disable iff (reset)
      (issue && !rsp_take) |=> (pending_ff == $past(pending_ff) + 1'b1))
      else $error("issue not counted");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty || back_valid) |-> (pending_ff != '0))
      else $error("result without an outstanding request");

endmodule
